@@ hw/rtl/c_header_tokenizer_top_defines.svh @@
// Assertion helpers used by the tokenizer top module.
// Both forms are clocked on clk_i and disabled while rst_ni is low.
`ifndef C_HEADER_TOKENIZER_TOP_DEFINES_SVH
`define C_HEADER_TOKENIZER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/chtok_pkg.sv @@
package chtok_pkg;

  // Scanner modes.
  typedef enum logic [3:0] {
    M_NORMAL    = 4'd0,
    M_SLASH     = 4'd1,
    M_LINESKIP  = 4'd2,
    M_BLOCK     = 4'd3,
    M_BLOCKSTAR = 4'd4,
    M_MINUS     = 4'd5,
    M_DOTS      = 4'd6,
    M_NUMBER    = 4'd7,
    M_IDENT     = 4'd8,
    M_STRING    = 4'd9,
    M_CHAR1     = 4'd10,
    M_CHAR2     = 4'd11
  } mode_e;

  // Token kinds as they appear on the output.
  typedef enum logic [3:0] {
    KIND_IDENT    = 4'd0,
    KIND_LPAREN   = 4'd1,
    KIND_RPAREN   = 4'd2,
    KIND_LBRACE   = 4'd3,
    KIND_RBRACE   = 4'd4,
    KIND_SEMI     = 4'd5,
    KIND_COMMA    = 4'd6,
    KIND_STAR     = 4'd7,
    KIND_ELLIPSIS = 4'd8,
    KIND_LBRACKET = 4'd9,
    KIND_RBRACKET = 4'd10,
    KIND_NUMBER   = 4'd11,
    KIND_STRING   = 4'd12,
    KIND_CHAR     = 4'd13,
    KIND_END      = 4'd15
  } kind_e;

  // Character codes the scanner looks for.
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One result token.
  typedef struct packed {
    kind_e       kind;
    logic [19:0] start;
    logic [20:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } tok_t;

  // All results caused by one input transaction.
  typedef struct packed {
    tok_t [2:0] toks;
    logic [1:0] count;
  } batch_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic tok_t mk_tok(kind_e k, logic [19:0] s, logic [20:0] l,
                                  logic [15:0] ln, logic [15:0] c);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.col   = c;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

@@ hw/rtl/c_header_tokenizer_top.sv @@
// Header text tokenizer.
// The slave stream takes one text byte per transaction: tdata is the byte,
// tuser says whether the byte is present and tlast marks the end of a text.
// The master stream gives one token per transaction: tuser is the token
// kind and tdata holds offset, length, line and column; tlast marks the
// final token caused by one input transaction. Every text ends with END.
// An input transaction passes the input register and then the output
// buffer before its first token reaches the master side.
// Throughput is one byte per cycle while each byte yields at most one token
// and the receiver takes every token; a byte that yields two or three tokens
// holds the input longer, set by the single token port of the output buffer.
// Reset empties both registers and puts the scanner at offset 0, line 1,
// column 1 in normal mode. When the receiver stalls, held tokens stay
// stable, the input register fills and tready drops until space frees.
`include "c_header_tokenizer_top_defines.svh"

module c_header_tokenizer_top #(
  parameter longint unsigned MAX_TEXT_BYTES = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] start_offset, [40:20] token_length, [56:41] line_number,
  // [72:57] column_number, [79:73] zero
  output logic [79:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);
  import chtok_pkg::*;

  localparam logic [19:0] POS_CAP =
    (MAX_TEXT_BYTES > 64'hFFFFF) ? 20'hFFFFF : 20'(MAX_TEXT_BYTES);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       bvalid_q;
  logic       eot_q;
  logic       buf_free;
  logic       proc_fire;
  batch_t     batch;
  tok_t       head;

  assign proc_fire     = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || proc_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q   <= s_axis_tdata;
      bvalid_q <= s_axis_tuser;
      eot_q    <= s_axis_tlast;
    end
  end

  // Scanner with its state.
  chtok_scan #(
    .POS_CAP(POS_CAP)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (proc_fire),
    .text_byte_i  (byte_q),
    .byte_valid_i (bvalid_q),
    .end_of_text_i(eot_q),
    .batch_o      (batch)
  );

  // Result buffer feeding the master stream.
  chtok_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proc_fire),
    .batch_i    (batch),
    .pop_ready_i(m_axis_tready),
    .free_o     (buf_free),
    .valid_o    (m_axis_tvalid),
    .head_o     (head)
  );

  assign m_axis_tdata = {7'd0, head.col, head.line, head.len, head.start};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // Checks.
  `CHT_ASSERT_NOW(a_end_is_last, m_axis_tvalid && (m_axis_tuser == KIND_END), m_axis_tlast, "END token is not the last of its run")
  `CHT_ASSERT_NOW(a_end_len_zero, m_axis_tvalid && (m_axis_tuser == KIND_END), m_axis_tdata[40:20] == 21'd0, "END token with nonzero length")
  `CHT_ASSERT_NOW(a_pos_nonzero, m_axis_tvalid, (m_axis_tdata[56:41] != 16'd0) && (m_axis_tdata[72:57] != 16'd0), "token with line or column zero")
  `CHT_ASSERT_NEXT(a_input_held, in_valid_q && !proc_fire, in_valid_q, "input transaction lost while stalled")

endmodule

@@ hw/rtl/chtok_scan.sv @@
module chtok_scan #(
  parameter logic [19:0] POS_CAP = 20'hFFFFF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        text_byte_i,
  input  logic              byte_valid_i,
  input  logic              end_of_text_i,
  output chtok_pkg::batch_t batch_o
);
  import chtok_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  dot_q, dot_d;
  logic        esc_q, esc_d;
  logic [19:0] pos_q, pos_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [19:0] tstart_q, tstart_d;
  logic [15:0] tline_q, tline_d;
  logic [15:0] tcol_q, tcol_d;

  logic [19:0] here;
  logic [20:0] incl;
  logic [19:0] here_end;
  logic        again;
  logic        pk_hit;
  kind_e       pk_kind;
  logic [1:0]  n;
  batch_t      batch;

  // Single-character punctuation decode.
  always_comb begin
    pk_hit  = 1'b1;
    pk_kind = KIND_IDENT;
    case (text_byte_i)
      CH_LPAREN:   pk_kind = KIND_LPAREN;
      CH_RPAREN:   pk_kind = KIND_RPAREN;
      CH_LBRACE:   pk_kind = KIND_LBRACE;
      CH_RBRACE:   pk_kind = KIND_RBRACE;
      CH_SEMI:     pk_kind = KIND_SEMI;
      CH_COMMA:    pk_kind = KIND_COMMA;
      CH_STAR:     pk_kind = KIND_STAR;
      CH_LBRACKET: pk_kind = KIND_LBRACKET;
      CH_RBRACKET: pk_kind = KIND_RBRACKET;
      default:     pk_hit  = 1'b0;
    endcase
  end

  assign here     = pos_q - tstart_q;
  assign incl     = {1'b0, here} + 21'd1;

  // Scan one byte, then flush the pending token and close the text if asked.
  always_comb begin
    mode_d   = mode_q;
    dot_d    = dot_q;
    esc_d    = esc_q;
    pos_d    = pos_q;
    line_d   = line_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    batch    = '0;
    n        = 2'd0;
    again    = 1'b0;
    here_end = 20'd0;

    if (byte_valid_i) begin
      case (mode_q)
        M_SLASH: begin
          if (text_byte_i == CH_SLASH) begin
            mode_d = M_LINESKIP;
          end else if (text_byte_i == CH_STAR) begin
            mode_d = M_BLOCK;
          end else begin
            again = 1'b1;
          end
        end
        M_LINESKIP: begin
          if (text_byte_i == CH_LF) mode_d = M_NORMAL;
        end
        M_BLOCK: begin
          if (text_byte_i == CH_STAR) mode_d = M_BLOCKSTAR;
        end
        M_BLOCKSTAR: begin
          if (text_byte_i == CH_SLASH) begin
            mode_d = M_NORMAL;
          end else if (text_byte_i != CH_STAR) begin
            mode_d = M_BLOCK;
          end
        end
        M_MINUS: begin
          if (is_digit(text_byte_i)) begin
            mode_d = M_NUMBER;
          end else begin
            again = 1'b1;
          end
        end
        M_DOTS: begin
          if (text_byte_i == CH_DOT) begin
            if (dot_q >= 2'd2) begin
              batch.toks[n] = mk_tok(KIND_ELLIPSIS, tstart_q, incl, tline_q, tcol_q);
              n      = n + 2'd1;
              dot_d  = 2'd0;
              mode_d = M_NORMAL;
            end else begin
              dot_d = dot_q + 2'd1;
            end
          end else begin
            dot_d = 2'd0;
            again = 1'b1;
          end
        end
        M_NUMBER: begin
          if (!(is_digit(text_byte_i) || is_alpha(text_byte_i) ||
                (text_byte_i == CH_DOT))) begin
            batch.toks[n] = mk_tok(KIND_NUMBER, tstart_q, {1'b0, here}, tline_q, tcol_q);
            n     = n + 2'd1;
            again = 1'b1;
          end
        end
        M_IDENT: begin
          if (!(is_digit(text_byte_i) || is_alpha(text_byte_i) ||
                (text_byte_i == CH_UNDER))) begin
            batch.toks[n] = mk_tok(KIND_IDENT, tstart_q, {1'b0, here}, tline_q, tcol_q);
            n     = n + 2'd1;
            again = 1'b1;
          end
        end
        M_STRING: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (text_byte_i == CH_BACKSLASH) begin
            esc_d = 1'b1;
          end else if (text_byte_i == CH_DQUOTE) begin
            batch.toks[n] = mk_tok(KIND_STRING, tstart_q, incl, tline_q, tcol_q);
            n      = n + 2'd1;
            mode_d = M_NORMAL;
          end
        end
        M_CHAR1: begin
          mode_d = M_CHAR2;
        end
        M_CHAR2: begin
          if (text_byte_i == CH_SQUOTE) begin
            batch.toks[n] = mk_tok(KIND_CHAR, tstart_q, incl, tline_q, tcol_q);
            n      = n + 2'd1;
            mode_d = M_NORMAL;
          end else begin
            batch.toks[n] = mk_tok(KIND_CHAR, tstart_q, {1'b0, here}, tline_q, tcol_q);
            n     = n + 2'd1;
            again = 1'b1;
          end
        end
        default: begin
          again = 1'b1;
        end
      endcase

      // The byte starts fresh in normal mode.
      if (again) begin
        mode_d = M_NORMAL;
        if (pk_hit) begin
          batch.toks[n] = mk_tok(pk_kind, pos_q, 21'd1, line_q, col_q);
          n = n + 2'd1;
        end else if (text_byte_i == CH_SLASH) begin
          mode_d = M_SLASH;
        end else if (text_byte_i == CH_HASH) begin
          mode_d = M_LINESKIP;
        end else if ((text_byte_i == CH_DOT) || is_digit(text_byte_i) ||
                     (text_byte_i == CH_MINUS) || (text_byte_i == CH_DQUOTE) ||
                     (text_byte_i == CH_SQUOTE) || is_alpha(text_byte_i) ||
                     (text_byte_i == CH_UNDER)) begin
          tstart_d = pos_q;
          tline_d  = line_q;
          tcol_d   = col_q;
          if (text_byte_i == CH_DOT) begin
            mode_d = M_DOTS;
            dot_d  = 2'd1;
          end else if (is_digit(text_byte_i)) begin
            mode_d = M_NUMBER;
          end else if (text_byte_i == CH_MINUS) begin
            mode_d = M_MINUS;
          end else if (text_byte_i == CH_DQUOTE) begin
            mode_d = M_STRING;
            esc_d  = 1'b0;
          end else if (text_byte_i == CH_SQUOTE) begin
            mode_d = M_CHAR1;
          end else begin
            mode_d = M_IDENT;
          end
        end
      end

      // Every byte moves the position; counters saturate.
      if (text_byte_i == CH_LF) begin
        if (line_q < COUNT_MAX) line_d = line_q + 16'd1;
        col_d = 16'd1;
      end else if (col_q < COUNT_MAX) begin
        col_d = col_q + 16'd1;
      end
      if (pos_q < POS_CAP) pos_d = pos_q + 20'd1;
    end

    // End of text: pending token, END, then back to the reset state.
    if (end_of_text_i) begin
      here_end = pos_d - tstart_d;
      case (mode_d)
        M_NUMBER: begin
          batch.toks[n] = mk_tok(KIND_NUMBER, tstart_d, {1'b0, here_end}, tline_d, tcol_d);
          n = n + 2'd1;
        end
        M_IDENT: begin
          batch.toks[n] = mk_tok(KIND_IDENT, tstart_d, {1'b0, here_end}, tline_d, tcol_d);
          n = n + 2'd1;
        end
        M_STRING: begin
          batch.toks[n] = mk_tok(KIND_STRING, tstart_d, {1'b0, here_end}, tline_d, tcol_d);
          n = n + 2'd1;
        end
        M_CHAR1, M_CHAR2: begin
          batch.toks[n] = mk_tok(KIND_CHAR, tstart_d, {1'b0, here_end}, tline_d, tcol_d);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      batch.toks[n] = mk_tok(KIND_END, pos_d, 21'd0, line_d, col_d);
      n = n + 2'd1;

      mode_d   = M_NORMAL;
      dot_d    = 2'd0;
      esc_d    = 1'b0;
      pos_d    = 20'd0;
      line_d   = 16'd1;
      col_d    = 16'd1;
      tstart_d = 20'd0;
      tline_d  = 16'd1;
      tcol_d   = 16'd1;
    end

    if (n != 2'd0) batch.toks[n - 2'd1].last = 1'b1;
    batch.count = n;
  end

  assign batch_o = batch;

  // Scanner state advances once per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_NORMAL;
      dot_q    <= 2'd0;
      esc_q    <= 1'b0;
      pos_q    <= 20'd0;
      line_q   <= 16'd1;
      col_q    <= 16'd1;
      tstart_q <= 20'd0;
      tline_q  <= 16'd1;
      tcol_q   <= 16'd1;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      dot_q    <= dot_d;
      esc_q    <= esc_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      col_q    <= col_d;
      tstart_q <= tstart_d;
      tline_q  <= tline_d;
      tcol_q   <= tcol_d;
    end
  end

endmodule

@@ hw/rtl/chtok_obuf.sv @@
module chtok_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  chtok_pkg::batch_t batch_i,
  input  logic              pop_ready_i,
  output logic              free_o,
  output logic              valid_o,
  output chtok_pkg::tok_t   head_o
);
  import chtok_pkg::*;

  tok_t       ent_q [3];
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  // A new batch may enter when the buffer is empty or its last held token leaves this cycle.
  assign free_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign head_o  = ent_q[0];

  // Token payload: load a whole batch or shift toward the head.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= batch_i.toks[0];
      ent_q[1] <= batch_i.toks[1];
      ent_q[2] <= batch_i.toks[2];
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import chtok_pkg::*;

  localparam longint unsigned TEXT_BYTES_MAX = 1048576;
  localparam int unsigned POS_CAP =
    (TEXT_BYTES_MAX > 1048575) ? 1048575 : 32'(TEXT_BYTES_MAX);
  localparam int unsigned IDLE_PCT = 32;
  localparam int unsigned RANDOM_ITEMS = 160;
  localparam int unsigned FULL_RATE_ITEMS = 40;
  localparam int unsigned CYCLE_LIMIT = 20000;

  // One token as the scanner should report it.
  typedef struct {
    kind_e       kind;
    logic [19:0] start;
    logic [20:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Idle enables for the byte source and the token sink.
  logic        src_idle = 1'b0;
  logic        sink_idle = 1'b0;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned item_count = 0;
  int unsigned text_count = 0;
  int unsigned tokens_seen = 0;

  // Tokens still to come out of the block, oldest first.
  token_t      lexed_tokens[$];
  token_t      lx_batch[$];

  // Scanner state of the predictor.
  mode_e       lx_mode;
  int unsigned lx_dots;
  logic        lx_escape;
  int unsigned lx_pos;
  int unsigned lx_line;
  int unsigned lx_col;
  int unsigned lx_tstart;
  int unsigned lx_tline;
  int unsigned lx_tcol;

  c_header_tokenizer_top #(
    .MAX_TEXT_BYTES(TEXT_BYTES_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Character classes.
  function automatic logic dec_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic ascii_letter(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic void lex_clear();
    lx_mode   = M_NORMAL;
    lx_dots   = 0;
    lx_escape = 1'b0;
    lx_pos    = 0;
    lx_line   = 1;
    lx_col    = 1;
    lx_tstart = 0;
    lx_tline  = 1;
    lx_tcol   = 1;
  endfunction

  function automatic void lex_emit(kind_e k, int unsigned s, int unsigned n,
                                   int unsigned ln, int unsigned c);
    token_t t;
    t.kind  = k;
    t.start = s[19:0];
    t.len   = n[20:0];
    t.line  = ln[15:0];
    t.col   = c[15:0];
    t.last  = 1'b0;
    lx_batch.insert(lx_batch.size(), t);
  endfunction

  // Remember where the token that begins at this byte starts.
  function automatic void lex_mark(mode_e m);
    lx_mode   = m;
    lx_tstart = lx_pos;
    lx_tline  = lx_line;
    lx_tcol   = lx_col;
  endfunction

  // A byte seen in normal mode: punctuation, or the opening of something longer.
  function automatic void lex_fresh(logic [7:0] b);
    lx_mode = M_NORMAL;
    case (b)
      CH_LPAREN:   lex_emit(KIND_LPAREN, lx_pos, 1, lx_line, lx_col);
      CH_RPAREN:   lex_emit(KIND_RPAREN, lx_pos, 1, lx_line, lx_col);
      CH_LBRACE:   lex_emit(KIND_LBRACE, lx_pos, 1, lx_line, lx_col);
      CH_RBRACE:   lex_emit(KIND_RBRACE, lx_pos, 1, lx_line, lx_col);
      CH_SEMI:     lex_emit(KIND_SEMI, lx_pos, 1, lx_line, lx_col);
      CH_COMMA:    lex_emit(KIND_COMMA, lx_pos, 1, lx_line, lx_col);
      CH_STAR:     lex_emit(KIND_STAR, lx_pos, 1, lx_line, lx_col);
      CH_LBRACKET: lex_emit(KIND_LBRACKET, lx_pos, 1, lx_line, lx_col);
      CH_RBRACKET: lex_emit(KIND_RBRACKET, lx_pos, 1, lx_line, lx_col);
      CH_SLASH:    lx_mode = M_SLASH;
      CH_HASH:     lx_mode = M_LINESKIP;
      CH_DOT: begin
        lex_mark(M_DOTS);
        lx_dots = 1;
      end
      CH_MINUS:    lex_mark(M_MINUS);
      CH_DQUOTE: begin
        lex_mark(M_STRING);
        lx_escape = 1'b0;
      end
      CH_SQUOTE:   lex_mark(M_CHAR1);
      default: begin
        if (dec_digit(b)) lex_mark(M_NUMBER);
        else if (ascii_letter(b) || (b == CH_UNDER)) lex_mark(M_IDENT);
      end
    endcase
  endfunction

  // One text byte: continue the current mode, then advance the position.
  function automatic void lex_byte(logic [7:0] b);
    int unsigned here;
    int unsigned incl;
    logic        again;
    here  = lx_pos - lx_tstart;
    incl  = here + 1;
    again = 1'b0;
    case (lx_mode)
      M_SLASH: begin
        if (b == CH_SLASH) lx_mode = M_LINESKIP;
        else if (b == CH_STAR) lx_mode = M_BLOCK;
        else again = 1'b1;
      end
      M_LINESKIP: if (b == CH_LF) lx_mode = M_NORMAL;
      M_BLOCK:    if (b == CH_STAR) lx_mode = M_BLOCKSTAR;
      M_BLOCKSTAR: begin
        if (b == CH_SLASH) lx_mode = M_NORMAL;
        else if (b != CH_STAR) lx_mode = M_BLOCK;
      end
      M_MINUS: begin
        if (dec_digit(b)) lx_mode = M_NUMBER;
        else again = 1'b1;
      end
      M_DOTS: begin
        if (b == CH_DOT) begin
          if (lx_dots >= 2) begin
            lex_emit(KIND_ELLIPSIS, lx_tstart, incl, lx_tline, lx_tcol);
            lx_dots = 0;
            lx_mode = M_NORMAL;
          end else begin
            lx_dots++;
          end
        end else begin
          lx_dots = 0;
          again   = 1'b1;
        end
      end
      M_NUMBER: begin
        if (!(dec_digit(b) || ascii_letter(b) || (b == CH_DOT))) begin
          lex_emit(KIND_NUMBER, lx_tstart, here, lx_tline, lx_tcol);
          again = 1'b1;
        end
      end
      M_IDENT: begin
        if (!(dec_digit(b) || ascii_letter(b) || (b == CH_UNDER))) begin
          lex_emit(KIND_IDENT, lx_tstart, here, lx_tline, lx_tcol);
          again = 1'b1;
        end
      end
      M_STRING: begin
        if (lx_escape) begin
          lx_escape = 1'b0;
        end else if (b == CH_BACKSLASH) begin
          lx_escape = 1'b1;
        end else if (b == CH_DQUOTE) begin
          lex_emit(KIND_STRING, lx_tstart, incl, lx_tline, lx_tcol);
          lx_mode = M_NORMAL;
        end
      end
      M_CHAR1: lx_mode = M_CHAR2;
      M_CHAR2: begin
        if (b == CH_SQUOTE) begin
          lex_emit(KIND_CHAR, lx_tstart, incl, lx_tline, lx_tcol);
          lx_mode = M_NORMAL;
        end else begin
          lex_emit(KIND_CHAR, lx_tstart, here, lx_tline, lx_tcol);
          again = 1'b1;
        end
      end
      default: again = 1'b1;
    endcase
    if (again) lex_fresh(b);

    // Every byte moves the position; counters saturate.
    if (b == CH_LF) begin
      if (lx_line < COUNT_MAX) lx_line++;
      lx_col = 1;
    end else if (lx_col < COUNT_MAX) begin
      lx_col++;
    end
    if (lx_pos < POS_CAP) lx_pos++;
  endfunction

  // End of text: flush an open token, report END, and start over.
  function automatic void lex_close();
    int unsigned here;
    here = lx_pos - lx_tstart;
    case (lx_mode)
      M_NUMBER: lex_emit(KIND_NUMBER, lx_tstart, here, lx_tline, lx_tcol);
      M_IDENT:  lex_emit(KIND_IDENT, lx_tstart, here, lx_tline, lx_tcol);
      M_STRING: lex_emit(KIND_STRING, lx_tstart, here, lx_tline, lx_tcol);
      M_CHAR1,
      M_CHAR2:  lex_emit(KIND_CHAR, lx_tstart, here, lx_tline, lx_tcol);
      default: ;
    endcase
    lex_emit(KIND_END, lx_pos, 0, lx_line, lx_col);
    lex_clear();
  endfunction

  // Tokens caused by one input transaction, the last one marked.
  function automatic void lex_item(logic [7:0] b, logic bv, logic eot);
    lx_batch.delete();
    if (bv) lex_byte(b);
    if (eot) lex_close();
    if (lx_batch.size() > 0) lx_batch[lx_batch.size() - 1].last = 1'b1;
    foreach (lx_batch[i]) lexed_tokens.insert(lexed_tokens.size(), lx_batch[i]);
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Token sink: random back-pressure while enabled.
  always @(negedge clk_i) begin
    m_axis_tready <= sink_idle ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // Compare every token transaction with the oldest predicted token.
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tokens_seen++;
      if (lexed_tokens.size() == 0) begin
        $error("token_kind: expected no token, got %0d", m_axis_tuser);
        errors++;
      end else begin
        want = lexed_tokens.pop_front();
        check_field("token_kind", want.kind, m_axis_tuser);
        check_field("start_offset", want.start, m_axis_tdata[19:0]);
        check_field("token_length", want.len, m_axis_tdata[40:20]);
        check_field("line_number", want.line, m_axis_tdata[56:41]);
        check_field("column_number", want.col, m_axis_tdata[72:57]);
        check_field("tdata_pad", 0, m_axis_tdata[79:73]);
        check_field("last_of_run", want.last, m_axis_tlast);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one input transaction; called and returning at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic eot);
    while (src_idle && ($urandom_range(99) < IDLE_PCT)) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = bv;
    s_axis_tlast  = eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lex_item(b, bv, eot);
    if (bv || eot) item_count++;
    if (eot) text_count++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, closes && (i == s.len() - 1));
    end
  endtask

  // Hold the source until every predicted token has been seen.
  task automatic drain_tokens();
    s_axis_tvalid = 1'b0;
    while (lexed_tokens.size() != 0) @(negedge clk_i);
  endtask

  // A random byte between two codes.
  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Append one byte to a text under construction.
  function automatic void put_byte(ref logic [7:0] txt[$], input logic [7:0] b);
    txt.insert(txt.size(), b);
  endfunction

  function automatic logic [7:0] rand_ident_char();
    case ($urandom_range(3))
      0:       return rand_byte("a", "z");
      1:       return rand_byte("A", "Z");
      2:       return rand_byte("0", "9");
      default: return CH_UNDER;
    endcase
  endfunction

  // Append one random lexical fragment, mostly well formed.
  task automatic add_fragment(ref logic [7:0] txt[$]);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    n    = $urandom_range(6);
    if (pick < 18) begin
      put_byte(txt, ($urandom_range(4) == 0) ? CH_UNDER : rand_byte("a", "z"));
      repeat (n) put_byte(txt, rand_ident_char());
    end else if (pick < 30) begin
      if ($urandom_range(2) == 0) put_byte(txt, CH_MINUS);
      put_byte(txt, rand_byte("0", "9"));
      repeat (n) put_byte(txt, ($urandom_range(4) == 0) ? CH_DOT : rand_ident_char());
    end else if (pick < 38) begin
      put_byte(txt, CH_DQUOTE);
      repeat (n) begin
        case ($urandom_range(5))
          0: begin
            put_byte(txt, CH_BACKSLASH);
            put_byte(txt, rand_byte(0, 255));
          end
          1:       put_byte(txt, rand_byte(0, 255));
          2:       put_byte(txt, " ");
          default: put_byte(txt, rand_ident_char());
        endcase
      end
      if ($urandom_range(9) != 0) put_byte(txt, CH_DQUOTE);
    end else if (pick < 44) begin
      put_byte(txt, CH_SQUOTE);
      put_byte(txt, ($urandom_range(1) == 0) ? rand_ident_char() : rand_byte(0, 255));
      if ($urandom_range(4) != 0) put_byte(txt, CH_SQUOTE);
    end else if (pick < 60) begin
      case ($urandom_range(8))
        0:       put_byte(txt, CH_LPAREN);
        1:       put_byte(txt, CH_RPAREN);
        2:       put_byte(txt, CH_LBRACE);
        3:       put_byte(txt, CH_RBRACE);
        4:       put_byte(txt, CH_SEMI);
        5:       put_byte(txt, CH_COMMA);
        6:       put_byte(txt, CH_STAR);
        7:       put_byte(txt, CH_LBRACKET);
        default: put_byte(txt, CH_RBRACKET);
      endcase
    end else if (pick < 64) begin
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 3) put_byte(txt, CH_DOT);
    end else if (pick < 70) begin
      if ($urandom_range(1) == 0) begin
        put_byte(txt, CH_HASH);
      end else begin
        put_byte(txt, CH_SLASH);
        put_byte(txt, CH_SLASH);
      end
      repeat (n) put_byte(txt, ($urandom_range(3) == 0) ? " " : rand_ident_char());
      put_byte(txt, CH_LF);
    end else if (pick < 76) begin
      put_byte(txt, CH_SLASH);
      put_byte(txt, CH_STAR);
      repeat (n) begin
        case ($urandom_range(3))
          0:       put_byte(txt, CH_STAR);
          1:       put_byte(txt, CH_SLASH);
          2:       put_byte(txt, CH_LF);
          default: put_byte(txt, rand_ident_char());
        endcase
      end
      repeat ($urandom_range(1, 2)) put_byte(txt, CH_STAR);
      put_byte(txt, CH_SLASH);
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0:       put_byte(txt, " ");
        1:       put_byte(txt, "\t");
        2:       put_byte(txt, "\r");
        default: put_byte(txt, CH_LF);
      endcase
    end else if (pick < 95) begin
      case ($urandom_range(2))
        0:       put_byte(txt, CH_MINUS);
        1:       put_byte(txt, CH_SLASH);
        default: put_byte(txt, CH_DOT);
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) put_byte(txt, rand_byte(0, 255));
    end
  endtask

  // A text with no bytes, and an empty transaction that must be ignored.
  task automatic test_empty_text();
    send_item(rand_byte(0, 255), 1'b0, 1'b0);
    send_item(rand_byte(0, 255), 1'b0, 1'b1);
  endtask

  // All punctuation, an identifier, a negative number and an ellipsis.
  task automatic test_punctuation();
    send_text("{f(-1.e,*_b)[]};...", 1'b1);
  endtask

  // Comments, a line directive, an escaped string, char literals, and a cut
  // char literal at the end that gives three tokens for one byte.
  task automatic test_literals_and_comments();
    send_text("/*/*/#\n\"\\\"\"'c'x'", 1'b1);
  endtask

  // Dropped bytes, high bytes, and tokens left open at the end of a text.
  task automatic test_strays_and_ends();
    send_text("- /.", 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("\"a", 1'b1);
    send_text("/*", 1'b1);
    send_text("a..", 1'b1);
    send_text("'c", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Random texts built from fragments, with idling on both sides.
  task automatic test_random_texts();
    logic [7:0]  txt[$];
    int unsigned first_item;
    int unsigned style;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    first_item = item_count;
    while (item_count - first_item < RANDOM_ITEMS) begin
      txt.delete();
      repeat ($urandom_range(1, 12)) add_fragment(txt);
      style = $urandom_range(9);
      if (style == 0) txt.delete();
      foreach (txt[i]) begin
        if ($urandom_range(19) == 0) send_item(rand_byte(0, 255), 1'b0, 1'b0);
        send_item(txt[i], 1'b1, (style >= 5) && (i == txt.size() - 1));
      end
      if ((style < 5) || (txt.size() == 0)) send_item(rand_byte(0, 255), 1'b0, 1'b1);
      if ($urandom_range(7) == 0) drain_tokens();
    end
  endtask

  // One random text sent back to back with no idling on either side.
  task automatic test_full_rate();
    logic [7:0] txt[$];
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    while (txt.size() < FULL_RATE_ITEMS) add_fragment(txt);
    foreach (txt[i]) send_item(txt[i], 1'b1, i == txt.size() - 1);
  endtask

  initial begin
    lex_clear();
    repeat (11) @(negedge clk_i);
    rst_ni    = 1'b1;
    src_idle  = 1'b1;
    sink_idle = 1'b1;

    test_empty_text();
    test_punctuation();
    test_literals_and_comments();
    test_strays_and_ends();
    drain_tokens();
    test_random_texts();
    drain_tokens();
    test_full_rate();
    drain_tokens();
    repeat (20) @(posedge clk_i);

    $display("Tokenized %0d texts from %0d input transactions, %0d tokens checked.",
             text_count, item_count, tokens_seen);
    $display("Directed cases, random fragment texts under stalls, and a full-rate text.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
